### hdl/ljpi_pkg.sv
// shared constants, types and register codes for the lennard-jones pair impulse block
`default_nettype none
package ljpi_pkg;

   localparam int POS_W       = 24;
   localparam int D_W         = POS_W + 1;
   localparam int MAG_W       = POS_W;
   localparam int SQ_W        = 2 * MAG_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int FRAC_W      = 16;
   localparam int R_W         = SUM_W - FRAC_W;
   localparam int CUT_W       = 32;
   localparam int DT_W        = 16;
   localparam int WIDE_W      = 64;
   localparam int HALF_W      = WIDE_W / 2;
   localparam int PP_W        = HALF_W + MAG_W;
   localparam int MAGI_W      = PP_W + 1;
   localparam int IMP_W       = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int U7_LIMIT_BIT = 57;

   localparam int DISP_STAGES = 3;
   localparam int DIV_STAGES  = 49;
   localparam int Q_W         = DIV_STAGES;
   localparam int QMUL_STAGES = 2;
   localparam int IMP_STAGES  = 4;
   localparam int SIDE_DELAY  = DIV_STAGES + 3 * QMUL_STAGES;
   localparam int LATENCY     = DISP_STAGES + SIDE_DELAY + IMP_STAGES;

   localparam logic [WIDE_W-1:0] FORCE_A = WIDE_W'(24);
   localparam logic [WIDE_W-1:0] FORCE_B = WIDE_W'(48);

   localparam logic [POS_W-1:0] BOX_LENGTH_RESET      = POS_W'(1966080);
   localparam logic [CUT_W-1:0] CUTOFF_SAME_RESET     = CUT_W'(409600);
   localparam logic [CUT_W-1:0] CUTOFF_CROSS_RESET    = CUT_W'(82570);
   localparam logic [DT_W-1:0]  TIME_STEP_RESET       = DT_W'(328);

   typedef enum logic [1:0] {
      CSR_BOX_LENGTH,
      CSR_CUTOFF_SAME,
      CSR_CUTOFF_CROSS,
      CSR_TIME_STEP
   } csr_index_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] dm;
      logic [2:0]            dneg;
      logic                  in_cut;
      logic                  zero;
   } pair_side_type;

endpackage
`default_nettype wire

### hdl/ljpi_disp.sv
// minimum-image displacement, squared distance and cutoff test, three stages
`default_nettype none
module ljpi_disp (
   input  logic                                        clock,
   input  logic                                        en,
   input  logic [2:0][ljpi_pkg::POS_W-1:0]             first_pos,
   input  logic [2:0][ljpi_pkg::POS_W-1:0]             second_pos,
   input  logic                                        same_type,
   input  logic [ljpi_pkg::POS_W-1:0]                  box_length,
   input  logic [ljpi_pkg::CUT_W-1:0]                  cutoff_same_sq,
   input  logic [ljpi_pkg::CUT_W-1:0]                  cutoff_cross_sq,
   output logic [ljpi_pkg::CUT_W-1:0]                  r_sq,
   output ljpi_pkg::pair_side_type                     side
);
   import ljpi_pkg::*;

   logic signed [D_W-1:0] diff [3];
   logic signed [D_W+1:0] twice [3];
   logic signed [D_W+1:0] len;
   logic signed [D_W-1:0] len_d;
   logic signed [D_W-1:0] d_in [3];
   logic signed [D_W-1:0] d_ff [3];
   logic [CUT_W-1:0]      cut_a_ff;
   logic [D_W-1:0]        negd [3];
   logic [MAG_W-1:0]      dm_in [3];
   logic [MAG_W-1:0]      dm_ff [3];
   logic [2:0]            dneg_ff;
   logic [SQ_W-1:0]       sq_in [3];
   logic [SQ_W-1:0]       sq_ff [3];
   logic [CUT_W-1:0]      cut_b_ff;
   logic [SUM_W-1:0]      s_sum;
   logic [R_W-1:0]        rr;
   logic [CUT_W-1:0]      r_ff;
   pair_side_type         side_in;
   pair_side_type         side_ff;

   assign len   = $signed({3'b000, box_length});
   assign len_d = $signed({1'b0, box_length});

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]  = $signed({1'b0, second_pos[k]}) - $signed({1'b0, first_pos[k]});
         twice[k] = $signed({diff[k][D_W-1], diff[k], 1'b0});
         if (twice[k] < -len) begin
            d_in[k] = diff[k] + len_d;
         end else if (twice[k] > len) begin
            d_in[k] = diff[k] - len_d;
         end else begin
            d_in[k] = diff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= d_in[k];
         end
         cut_a_ff <= same_type ? cutoff_same_sq : cutoff_cross_sq;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         negd[k]  = -d_ff[k];
         dm_in[k] = d_ff[k][D_W-1] ? negd[k][MAG_W-1:0] : d_ff[k][MAG_W-1:0];
         sq_in[k] = SQ_W'(dm_in[k]) * SQ_W'(dm_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dm_ff[k]   <= dm_in[k];
            dneg_ff[k] <= d_ff[k][D_W-1];
            sq_ff[k]   <= sq_in[k];
         end
         cut_b_ff <= cut_a_ff;
      end
   end

   always_comb begin
      s_sum = SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      rr    = s_sum[SUM_W-1:FRAC_W];
      for (int k = 0; k < 3; k++) begin
         side_in.dm[k] = dm_ff[k];
      end
      side_in.dneg   = dneg_ff;
      side_in.in_cut = rr <= R_W'(cut_b_ff);
      side_in.zero   = rr == '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff    <= rr[CUT_W-1:0];
         side_ff <= side_in;
      end
   end

   assign r_sq = r_ff;
   assign side = side_ff;

endmodule
`default_nettype wire

### hdl/ljpi_div.sv
// pipelined restoring divider, one quotient bit per stage, forms 2^48 / r
`default_nettype none
module ljpi_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [ljpi_pkg::CUT_W-1:0]   divisor,
   output logic [ljpi_pkg::Q_W-1:0]     quotient
);
   import ljpi_pkg::*;

   logic [CUT_W-1:0] rem_ff [DIV_STAGES];
   logic [CUT_W-1:0] dvs_ff [DIV_STAGES];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [CUT_W-1:0] rem_prev;
      logic [CUT_W-1:0] dvs_prev;
      logic [Q_W-1:0]   q_prev;
      logic [CUT_W:0]   trial;
      logic [CUT_W:0]   diff;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign dvs_prev = divisor;
         assign q_prev   = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign dvs_prev = dvs_ff[k-1];
         assign q_prev   = q_ff[k-1];
      end

      // dividend has only its top bit set
      assign trial = {rem_prev, 1'(k == 0)};
      assign diff  = trial - {1'b0, dvs_prev};
      assign take  = trial >= {1'b0, dvs_prev};

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? diff[CUT_W-1:0] : trial[CUT_W-1:0];
            dvs_ff[k] <= dvs_prev;
            q_ff[k]   <= {q_prev[Q_W-2:0], take};
         end
      end
   end

   assign quotient = q_ff[DIV_STAGES-1];

endmodule
`default_nettype wire

### hdl/ljpi_qmul.sv
// two-stage saturating q32.32 multiply, 32x32 partial products then sum
`default_nettype none
module ljpi_qmul (
   input  logic                          clock,
   input  logic                          en,
   input  logic [ljpi_pkg::WIDE_W-1:0]   a,
   input  logic [ljpi_pkg::WIDE_W-1:0]   b,
   output logic [ljpi_pkg::WIDE_W-1:0]   p
);
   import ljpi_pkg::*;

   logic [WIDE_W-1:0]   p00_ff, p01_ff, p10_ff, p11_ff;
   logic [2*WIDE_W-1:0] sum;
   logic [WIDE_W-1:0]   p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p00_ff <= WIDE_W'(a[HALF_W-1:0]) * WIDE_W'(b[HALF_W-1:0]);
         p01_ff <= WIDE_W'(a[HALF_W-1:0]) * WIDE_W'(b[WIDE_W-1:HALF_W]);
         p10_ff <= WIDE_W'(a[WIDE_W-1:HALF_W]) * WIDE_W'(b[HALF_W-1:0]);
         p11_ff <= WIDE_W'(a[WIDE_W-1:HALF_W]) * WIDE_W'(b[WIDE_W-1:HALF_W]);
      end
   end

   assign sum = {{WIDE_W{1'b0}}, p00_ff}
              + {{HALF_W{1'b0}}, p01_ff, {HALF_W{1'b0}}}
              + {{HALF_W{1'b0}}, p10_ff, {HALF_W{1'b0}}}
              + {p11_ff, {WIDE_W{1'b0}}};

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= (sum[2*WIDE_W-1:WIDE_W+HALF_W] != '0) ? '1
               : sum[WIDE_W+HALF_W-1:HALF_W];
      end
   end

   assign p = p_ff;

endmodule
`default_nettype wire

### hdl/ljpi_impulse.sv
// force magnitude, time step scaling, per-axis impulse and saturation, four stages
`default_nettype none
module ljpi_impulse (
   input  logic                                   clock,
   input  logic                                   en,
   input  logic [ljpi_pkg::WIDE_W-1:0]            u4,
   input  logic [ljpi_pkg::WIDE_W-1:0]            u7,
   input  logic [ljpi_pkg::DT_W-1:0]              time_step,
   input  ljpi_pkg::pair_side_type                side,
   output logic [2:0][ljpi_pkg::IMP_W-1:0]        impulse,
   output logic                                   within_cutoff,
   output logic                                   clipped
);
   import ljpi_pkg::*;

   localparam logic [MAGI_W-1:0] NEG_LIMIT = MAGI_W'(1) << (IMP_W - 1);
   localparam logic [MAGI_W-1:0] POS_LIMIT = NEG_LIMIT - MAGI_W'(1);
   localparam logic [IMP_W-1:0]  IMP_MIN   = {1'b1, {(IMP_W-1){1'b0}}};
   localparam logic [IMP_W-1:0]  IMP_MAX   = ~IMP_MIN;

   logic [WIDE_W-1:0]      f;
   logic [WIDE_W-1:0]      fm_ff;
   logic                   fneg_f_ff, over_f_ff;
   pair_side_type          side_f_ff;

   logic [WIDE_W+DT_W-1:0] prod;
   logic [WIDE_W-1:0]      dfm_ff;
   logic                   fneg_g_ff, over_g_ff;
   pair_side_type          side_g_ff;

   logic [PP_W-1:0]        pp_lo_ff [3];
   logic [PP_W-1:0]        pp_hi_ff [3];
   logic                   fneg_h_ff, over_h_ff;
   pair_side_type          side_h_ff;

   logic [MAGI_W-1:0]      mag [3];
   logic [MAGI_W-1:0]      negm [3];
   logic                   neg [3];
   logic [2:0][IMP_W-1:0]  imp_in;
   logic [2:0]             clip_in;
   logic [2:0][IMP_W-1:0]  imp_ff;
   logic                   within_ff, clipped_ff;

   assign f = FORCE_A * u4 - FORCE_B * u7;

   always_ff @(posedge clock) begin
      if (en) begin
         fneg_f_ff <= f[WIDE_W-1];
         fm_ff     <= f[WIDE_W-1] ? -f : f;
         over_f_ff <= side.zero || (u7[WIDE_W-1:U7_LIMIT_BIT] != '0);
         side_f_ff <= side;
      end
   end

   assign prod = (WIDE_W+DT_W)'(fm_ff) * (WIDE_W+DT_W)'(time_step);

   always_ff @(posedge clock) begin
      if (en) begin
         dfm_ff    <= prod[WIDE_W+DT_W-1:DT_W];
         fneg_g_ff <= fneg_f_ff;
         over_g_ff <= over_f_ff;
         side_g_ff <= side_f_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            pp_lo_ff[k] <= PP_W'(dfm_ff[HALF_W-1:0]) * PP_W'(side_g_ff.dm[k]);
            pp_hi_ff[k] <= PP_W'(dfm_ff[WIDE_W-1:HALF_W]) * PP_W'(side_g_ff.dm[k]);
         end
         fneg_h_ff <= fneg_g_ff;
         over_h_ff <= over_g_ff;
         side_h_ff <= side_g_ff;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mag[k]  = MAGI_W'(pp_hi_ff[k]) + MAGI_W'(pp_lo_ff[k][PP_W-1:HALF_W]);
         negm[k] = -mag[k];
         neg[k]  = fneg_h_ff ^ side_h_ff.dneg[k];
         imp_in[k]  = '0;
         clip_in[k] = 1'b0;
         if (!side_h_ff.in_cut || side_h_ff.dm[k] == '0) begin
            imp_in[k]  = '0;
         end else if (over_h_ff) begin
            clip_in[k] = 1'b1;
            imp_in[k]  = side_h_ff.dneg[k] ? IMP_MAX : IMP_MIN;
         end else if (neg[k]) begin
            if (mag[k] > NEG_LIMIT) begin
               clip_in[k] = 1'b1;
               imp_in[k]  = IMP_MIN;
            end else begin
               imp_in[k]  = negm[k][IMP_W-1:0];
            end
         end else begin
            if (mag[k] > POS_LIMIT) begin
               clip_in[k] = 1'b1;
               imp_in[k]  = IMP_MAX;
            end else begin
               imp_in[k]  = mag[k][IMP_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         imp_ff     <= imp_in;
         within_ff  <= side_h_ff.in_cut;
         clipped_ff <= |clip_in;
      end
   end

   assign impulse       = imp_ff;
   assign within_cutoff = within_ff;
   assign clipped       = clipped_ff;

endmodule
`default_nettype wire

### hdl/lennard_jones_pair_impulse.sv
// lennard-jones 12-6 pair impulse with minimum-image displacement, top level
// a request passes the displacement, divider, power and impulse stages in that order to the result
// throughput: one request per cycle while results are taken; the 49-stage one-bit-per-stage
// reciprocal divider sets most of the latency
// a result not taken holds the whole pipeline; no request is accepted during that cycle
// reset clears all valid bits and restores the register defaults
`default_nettype none
module lennard_jones_pair_impulse (
   input  logic                                  clock,
   input  logic                                  reset,
   // first_x, first_y, first_z, second_x, second_y, second_z
   input  logic [6*ljpi_pkg::POS_W-1:0]          req_tdata,
   // same_type
   input  logic                                  req_tuser,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // impulse_x, impulse_y, impulse_z
   output logic [3*ljpi_pkg::IMP_W-1:0]          rsp_tdata,
   // within_cutoff, clipped
   output logic [1:0]                            rsp_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  ljpi_pkg::csr_index_type               csr_index,
   input  logic [ljpi_pkg::CSR_DATA_W-1:0]       csr_data
);
   import ljpi_pkg::*;

   logic [POS_W-1:0]         box_length_ff;
   logic [CUT_W-1:0]         cutoff_same_ff;
   logic [CUT_W-1:0]         cutoff_cross_ff;
   logic [DT_W-1:0]          time_step_ff;

   logic                     en;
   logic [LATENCY-1:0]       valid_ff;

   logic [2:0][POS_W-1:0]    first_pos, second_pos;
   logic [CUT_W-1:0]         r_sq;
   pair_side_type            side_disp;
   pair_side_type            side_ff [SIDE_DELAY];
   logic [Q_W-1:0]           u_q;
   logic [WIDE_W-1:0]        u_ff [QMUL_STAGES];
   logic [WIDE_W-1:0]        u2, u3, u4, u7;
   logic [WIDE_W-1:0]        u4_ff [QMUL_STAGES];
   logic [2:0][IMP_W-1:0]    impulse;
   logic                     within_cutoff, clipped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_length_ff   <= BOX_LENGTH_RESET;
         cutoff_same_ff  <= CUTOFF_SAME_RESET;
         cutoff_cross_ff <= CUTOFF_CROSS_RESET;
         time_step_ff    <= TIME_STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_BOX_LENGTH:   box_length_ff   <= csr_data[POS_W-1:0];
            CSR_CUTOFF_SAME:  cutoff_same_ff  <= csr_data[CUT_W-1:0];
            CSR_CUTOFF_CROSS: cutoff_cross_ff <= csr_data[CUT_W-1:0];
            CSR_TIME_STEP:    time_step_ff    <= csr_data[DT_W-1:0];
            default: ;
         endcase
      end
   end

   assign en         = !valid_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LATENCY-2:0], req_tvalid};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         first_pos[k]  = req_tdata[k*POS_W +: POS_W];
         second_pos[k] = req_tdata[(k+3)*POS_W +: POS_W];
      end
   end

   ljpi_disp u_disp (
      .clock           (clock),
      .en              (en),
      .first_pos       (first_pos),
      .second_pos      (second_pos),
      .same_type       (req_tuser),
      .box_length      (box_length_ff),
      .cutoff_same_sq  (cutoff_same_ff),
      .cutoff_cross_sq (cutoff_cross_ff),
      .r_sq            (r_sq),
      .side            (side_disp)
   );

   ljpi_div u_div (
      .clock    (clock),
      .en       (en),
      .divisor  (r_sq),
      .quotient (u_q)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_disp;
         for (int k = 1; k < SIDE_DELAY; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         u_ff[0]  <= WIDE_W'(u_q);
         u4_ff[0] <= u4;
         for (int k = 1; k < QMUL_STAGES; k++) begin
            u_ff[k]  <= u_ff[k-1];
            u4_ff[k] <= u4_ff[k-1];
         end
      end
   end

   ljpi_qmul u_qmul_u2 (
      .clock (clock),
      .en    (en),
      .a     (WIDE_W'(u_q)),
      .b     (WIDE_W'(u_q)),
      .p     (u2)
   );

   ljpi_qmul u_qmul_u3 (
      .clock (clock),
      .en    (en),
      .a     (u2),
      .b     (u_ff[QMUL_STAGES-1]),
      .p     (u3)
   );

   ljpi_qmul u_qmul_u4 (
      .clock (clock),
      .en    (en),
      .a     (u2),
      .b     (u2),
      .p     (u4)
   );

   ljpi_qmul u_qmul_u7 (
      .clock (clock),
      .en    (en),
      .a     (u4),
      .b     (u3),
      .p     (u7)
   );

   ljpi_impulse u_impulse (
      .clock         (clock),
      .en            (en),
      .u4            (u4_ff[QMUL_STAGES-1]),
      .u7            (u7),
      .time_step     (time_step_ff),
      .side          (side_ff[SIDE_DELAY-1]),
      .impulse       (impulse),
      .within_cutoff (within_cutoff),
      .clipped       (clipped)
   );

   assign rsp_tdata  = impulse;
   assign rsp_tuser  = {clipped, within_cutoff};
   assign rsp_tvalid = valid_ff[LATENCY-1];

endmodule
`default_nettype wire

### hdl/ljpi_checker.sv
// port-level checks for the pair impulse block and their binding
`default_nettype none
module ljpi_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tready,
   input  logic [3*ljpi_pkg::IMP_W-1:0]          rsp_tdata,
   input  logic [1:0]                            rsp_tuser,
   input  logic                                  rsp_tvalid,
   input  logic                                  rsp_tready
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while result stalled");

   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("pair outside cutoff gave nonzero impulse");

   a_clip_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0] && rsp_tdata != '0)
      else $error("clipped without a saturated impulse");

endmodule

bind lennard_jones_pair_impulse ljpi_checker u_checker (.*);
`default_nettype wire
